[rtl/srrd_pkg.sv]
// ----------------------------------------------------------------------------
// srrd_pkg: shared types and constants of the run record decoder
// Operation codes, record modes, register indexes, header byte positions and
// the command word that travels from the parser to the result stage.
// ----------------------------------------------------------------------------
package srrd_pkg;

  // Result operation codes as they appear on the output tuser
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_SHADE = 2'd1,
    OP_END   = 2'd2
  } op_kind_t;

  // Record formats selected by the mode register (code 3 behaves as draw)
  localparam logic [1:0] MODE_DRAW  = 2'd0;
  localparam logic [1:0] MODE_SHADE = 2'd1;
  localparam logic [1:0] MODE_ANIM  = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_RECORD_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 1'd1;

  // Field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned HIDX_W   = 4;
  localparam int unsigned BASE_W   = 24;
  localparam int unsigned REL_W    = WORD_W + 1;
  localparam int unsigned ADDR_W   = 25;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned OUT_DATA_W = 40;

  // Sprite header byte positions
  localparam logic [HIDX_W-1:0] SPR_OFF_LO  = 4'd8;
  localparam logic [HIDX_W-1:0] SPR_OFF_HI  = 4'd9;
  localparam logic [HIDX_W-1:0] SPR_SIZE_LO = 4'd12;
  localparam logic [HIDX_W-1:0] SPR_SIZE_HI = 4'd13;
  localparam logic [HIDX_W-1:0] SPR_LAST    = 4'd15;

  // Animation header byte positions
  localparam logic [HIDX_W-1:0] ANM_TERM_LO = 4'd0;
  localparam logic [HIDX_W-1:0] ANM_TERM_HI = 4'd1;
  localparam logic [HIDX_W-1:0] ANM_POS_LO  = 4'd4;
  localparam logic [HIDX_W-1:0] ANM_POS_HI  = 4'd5;
  localparam logic [HIDX_W-1:0] ANM_LEN_LO  = 4'd6;
  localparam logic [HIDX_W-1:0] ANM_LEN_HI  = 4'd7;

  // Offset value that terminates a sprite record list
  localparam logic [WORD_W-1:0] END_OFFSET = 16'hFFFF;

  // Command passed from the parser to the result stage
  typedef struct packed {
    op_kind_t          kind;
    logic [BYTE_W-1:0] value;
    logic [REL_W-1:0]  rel_addr;
  } cmd_t;

endpackage

[rtl/srrd_front.sv]
// ----------------------------------------------------------------------------
// srrd_front: record parser
// Accepts one byte per cycle unless the queue is full, tracks the header and
// run counters and pushes a command per byte giving a pixel or end operation.
// ----------------------------------------------------------------------------
module srrd_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [srrd_pkg::BYTE_W-1:0]       in_byte,
  input  logic [srrd_pkg::MODE_W-1:0]       record_mode,
  input  logic                              q_full,
  output logic                              q_push,
  output srrd_pkg::cmd_t                    q_cmd
);

  // Parser phase
  typedef enum logic [1:0] {
    PH_HEADER  = 2'b01,
    PH_PAYLOAD = 2'b10
  } phase_t;

  phase_t                             phase_r, phase_nxt;
  logic [srrd_pkg::HIDX_W-1:0]        hidx_r, hidx_nxt;
  logic [srrd_pkg::WORD_W-1:0]        offset_r, offset_nxt;
  logic [srrd_pkg::WORD_W-1:0]        size_r, size_nxt;
  logic [srrd_pkg::WORD_W-1:0]        pos_r, pos_nxt;
  logic                               accept;
  logic                               emit;
  logic                               anim;
  logic [srrd_pkg::WORD_W-1:0]        pos_inc;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign anim      = (record_mode == srrd_pkg::MODE_ANIM);
  assign pos_inc   = pos_r + 16'd1;
  assign q_push    = accept && emit;

  // Next-state and command decode for the byte on the input
  always_comb begin
    phase_nxt        = phase_r;
    hidx_nxt         = hidx_r + 4'd1;
    offset_nxt       = offset_r;
    size_nxt         = size_r;
    pos_nxt          = pos_r;
    emit             = 1'b0;
    q_cmd.kind       = srrd_pkg::OP_END;
    q_cmd.value      = '0;
    q_cmd.rel_addr   = '0;

    case (phase_r)
      PH_PAYLOAD: begin
        // One pixel operation per payload byte
        emit           = 1'b1;
        hidx_nxt       = hidx_r;
        q_cmd.rel_addr = {1'b0, offset_r} + {1'b0, pos_r};
        if (record_mode == srrd_pkg::MODE_SHADE) begin
          q_cmd.kind  = srrd_pkg::OP_SHADE;
        end else begin
          q_cmd.kind  = srrd_pkg::OP_WRITE;
          q_cmd.value = in_byte;
        end
        pos_nxt = pos_inc;
        if (pos_inc == size_r) begin
          phase_nxt = PH_HEADER;
          hidx_nxt  = '0;
        end
      end
      PH_HEADER: begin
        if (anim) begin
          // Animation delta header: terminator word, position, length
          case (hidx_r)
            srrd_pkg::ANM_TERM_LO: offset_nxt = {8'h00, in_byte};
            srrd_pkg::ANM_TERM_HI: begin
              if (offset_r[7:0] == 8'h00 && in_byte == 8'h00) begin
                emit     = 1'b1;
                hidx_nxt = '0;
              end
            end
            srrd_pkg::ANM_POS_LO:  offset_nxt = {8'h00, in_byte};
            srrd_pkg::ANM_POS_HI:  offset_nxt = {in_byte, offset_r[7:0]};
            srrd_pkg::ANM_LEN_LO:  size_nxt   = {8'h00, in_byte};
            srrd_pkg::ANM_LEN_HI: begin
              size_nxt  = {in_byte, size_r[7:0]};
              hidx_nxt  = '0;
              pos_nxt   = '0;
              phase_nxt = ({in_byte, size_r[7:0]} != '0) ? PH_PAYLOAD : PH_HEADER;
            end
            default: ;
          endcase
        end else begin
          // Sprite header: offset, size, then payload after the last byte
          case (hidx_r)
            srrd_pkg::SPR_OFF_LO: offset_nxt = {8'h00, in_byte};
            srrd_pkg::SPR_OFF_HI: begin
              offset_nxt = {in_byte, offset_r[7:0]};
              if ({in_byte, offset_r[7:0]} == srrd_pkg::END_OFFSET) begin
                emit     = 1'b1;
                hidx_nxt = '0;
              end
            end
            srrd_pkg::SPR_SIZE_LO: size_nxt = {8'h00, in_byte};
            srrd_pkg::SPR_SIZE_HI: size_nxt = {in_byte, size_r[7:0]};
            srrd_pkg::SPR_LAST: begin
              hidx_nxt  = '0;
              pos_nxt   = '0;
              phase_nxt = (size_r != '0) ? PH_PAYLOAD : PH_HEADER;
            end
            default: ;
          endcase
        end
      end
      default: begin
        phase_nxt = PH_HEADER;
        hidx_nxt  = '0;
      end
    endcase
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      hidx_r   <= '0;
      offset_r <= '0;
      size_r   <= '0;
      pos_r    <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      hidx_r   <= hidx_nxt;
      offset_r <= offset_nxt;
      size_r   <= size_nxt;
      pos_r    <= pos_nxt;
    end
  end

endmodule

[rtl/srrd_queue.sv]
// ----------------------------------------------------------------------------
// srrd_queue: command queue
// A small first-in first-out buffer that lets the parser and the result stage
// stall independently of each other.
// ----------------------------------------------------------------------------
module srrd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  srrd_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output srrd_pkg::cmd_t pop_cmd
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  srrd_pkg::cmd_t   entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_cmd   = entry_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[rtl/srrd_back.sv]
// ----------------------------------------------------------------------------
// srrd_back: result stage
// Takes commands from the queue, adds the destination base and holds the
// finished result in an output register until the consumer takes it.
// ----------------------------------------------------------------------------
module srrd_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [srrd_pkg::BASE_W-1:0]       base_address,
  input  logic                              q_not_empty,
  input  srrd_pkg::cmd_t                    q_cmd,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [srrd_pkg::ADDR_W-1:0]       out_address,
  output logic [srrd_pkg::BYTE_W-1:0]       out_value,
  output srrd_pkg::op_kind_t                out_kind,
  output logic                              out_done
);

  logic                             valid_r;
  logic [srrd_pkg::ADDR_W-1:0]      address_r, address_nxt;
  logic [srrd_pkg::BYTE_W-1:0]      value_r;
  srrd_pkg::op_kind_t               kind_r;
  logic                             done_r;
  logic                             is_end;

  // Load a new result whenever the output register is empty or being drained
  assign q_pop  = q_not_empty && (!valid_r || out_ready);
  assign is_end = (q_cmd.kind == srrd_pkg::OP_END);

  // The end marker carries a fixed zero address
  always_comb begin
    if (is_end) begin
      address_nxt = '0;
    end else begin
      address_nxt = {1'b0, base_address} + {{(srrd_pkg::ADDR_W-srrd_pkg::REL_W){1'b0}},
                                           q_cmd.rel_addr};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      address_r <= address_nxt;
      value_r   <= q_cmd.value;
      kind_r    <= q_cmd.kind;
      done_r    <= is_end;
    end
  end

  assign out_valid   = valid_r;
  assign out_address = address_r;
  assign out_value   = value_r;
  assign out_kind    = kind_r;
  assign out_done    = done_r;

endmodule

[rtl/sprite_run_record_decoder_core.sv]
// ----------------------------------------------------------------------------
// sprite_run_record_decoder_core: run record stream to pixel operations
// Parses sprite and animation run records from a byte stream and issues
// pixel write, pixel shade and end-of-list operations.
//
//   Channel  Direction  Handshake          Payload
//   in_      slave      tvalid / tready    tdata[7:0] stream byte
//   out_     master     tvalid / tready    tdata address+value, tuser kind,
//                                          tlast end of list
//   cfg_     slave      valid / ready      index, data (register write)
//
// One stream byte is accepted per cycle; the parser updates its header and
// run counters as each byte is accepted. A result passes through the queue,
// then the output register. Reset is synchronous to clk and clears all
// control state. A stalled output fills the queue, after which in_tready
// falls; configuration writes are always accepted.
// ----------------------------------------------------------------------------
module sprite_run_record_decoder_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // stream_byte [7:0]
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [7:0]                             in_tdata,
  // pixel_address [24:0], pixel_value [32:25], zero fill [39:33]
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [srrd_pkg::OUT_DATA_W-1:0]        out_tdata,
  // op_kind [1:0]
  output logic [1:0]                             out_tuser,
  output logic                                   out_tlast,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [srrd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [srrd_pkg::BASE_W-1:0]            cfg_data
);

  logic [srrd_pkg::MODE_W-1:0]   record_mode_r;
  logic [srrd_pkg::BASE_W-1:0]   base_address_r;
  logic                          q_push;
  logic                          q_full;
  logic                          q_pop;
  logic                          q_not_empty;
  srrd_pkg::cmd_t                push_cmd;
  srrd_pkg::cmd_t                pop_cmd;
  logic [srrd_pkg::ADDR_W-1:0]   res_address;
  logic [srrd_pkg::BYTE_W-1:0]   res_value;
  srrd_pkg::op_kind_t            res_kind;
  logic                          res_done;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      record_mode_r  <= '0;
      base_address_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        srrd_pkg::REG_RECORD_MODE:  record_mode_r  <= cfg_data[srrd_pkg::MODE_W-1:0];
        srrd_pkg::REG_BASE_ADDRESS: base_address_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Parser
  srrd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_byte     (in_tdata),
    .record_mode (record_mode_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (push_cmd)
  );

  // Command queue
  srrd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_cmd   (pop_cmd)
  );

  // Result stage
  srrd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .base_address (base_address_r),
    .q_not_empty  (q_not_empty),
    .q_cmd        (pop_cmd),
    .q_pop        (q_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_address  (res_address),
    .out_value    (res_value),
    .out_kind     (res_kind),
    .out_done     (res_done)
  );

  // Output packing
  assign out_tdata = {7'd0, res_value, res_address};
  assign out_tuser = res_kind;
  assign out_tlast = res_done;

`ifndef SYNTH
  // The end-of-list request carries the end code and a zero address
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |->
      (out_tuser == srrd_pkg::OP_END && out_tdata[24:0] == '0))
    else $error("end of list result with wrong kind or address");

  // Shade requests carry a zero pixel value
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == srrd_pkg::OP_SHADE) |-> (out_tdata[32:25] == '0))
    else $error("shade result with non-zero pixel value");

  // The parser never pushes into a full queue
  assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command pushed into full queue");
`endif

endmodule

[tb/sv/tb_sprite_run_record_decoder_core.sv]
// ----------------------------------------------------------------------------
// tb_sprite_run_record_decoder_core: self-checking bench of the run decoder
// Feeds sprite and animation run record streams into the decoder under
// random back-pressure and compares every pixel operation with a predictor
// that tracks the header and run counters byte by byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_sprite_run_record_decoder_core;
  import srrd_pkg::*;

  // Mode code that has no format of its own and decodes as draw
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned SPR_HDR_BYTES = 16;
  localparam int unsigned ANM_HDR_BYTES = 8;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned QUIET_LIMIT   = 2000;

  // One predicted pixel operation
  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] value;
    op_kind_t          kind;
    logic              done;
  } pixel_op_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BASE_W-1:0] cfg_data = '0;

  // Predictor copy of the registers and parser state
  logic [MODE_W-1:0] rec_mode = MODE_DRAW;
  logic [BASE_W-1:0] base_addr = '0;
  logic              dec_in_run = 1'b0;
  logic [HIDX_W-1:0] dec_hdr_idx = '0;
  logic [WORD_W-1:0] dec_offset = '0;
  logic [WORD_W-1:0] dec_size = '0;
  logic [WORD_W-1:0] dec_pos = '0;

  pixel_op_t pending_ops[$];

  int in_gap_pct = 0;
  int out_stall_pct = 0;
  int error_count = 0;
  int n_bytes = 0;
  int n_cfg = 0;
  int n_writes = 0;
  int n_shades = 0;
  int n_ends = 0;
  int quiet_cycles = 0;

  sprite_run_record_decoder_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Clock generation
  initial begin
    forever #6 clk = ~clk;
  end

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Steps the parser model by one accepted stream byte and queues the
  // pixel operation it causes, if any.
  task automatic decode_stream_byte(input logic [7:0] b);
    pixel_op_t op;
    logic      emit;
    logic      advance;
    logic      start_run;
    emit = 1'b0;
    advance = 1'b1;
    start_run = 1'b0;
    op.addr = '0;
    op.value = '0;
    op.kind = OP_END;
    op.done = 1'b0;
    if (dec_in_run) begin
      op.addr = ADDR_W'(base_addr) + ADDR_W'(dec_offset) + ADDR_W'(dec_pos);
      if (rec_mode == MODE_SHADE) begin
        op.kind = OP_SHADE;
      end else begin
        op.kind = OP_WRITE;
        op.value = b;
      end
      emit = 1'b1;
      advance = 1'b0;
      dec_pos = dec_pos + 1'b1;
      if (dec_pos == dec_size) begin
        dec_in_run = 1'b0;
        dec_hdr_idx = '0;
      end
    end else if (rec_mode == MODE_ANIM) begin
      case (dec_hdr_idx)
        ANM_TERM_LO: dec_offset = {8'h00, b};
        ANM_TERM_HI: begin
          // A zero first word closes the list as soon as it is complete.
          if (dec_offset[7:0] == 8'h00 && b == 8'h00) begin
            emit = 1'b1;
            op.done = 1'b1;
            advance = 1'b0;
            dec_hdr_idx = '0;
          end
        end
        ANM_POS_LO: dec_offset = {8'h00, b};
        ANM_POS_HI: dec_offset[15:8] = b;
        ANM_LEN_LO: dec_size = {8'h00, b};
        ANM_LEN_HI: begin
          dec_size[15:8] = b;
          start_run = 1'b1;
        end
        default: ;
      endcase
    end else begin
      case (dec_hdr_idx)
        SPR_OFF_LO: dec_offset = {8'h00, b};
        SPR_OFF_HI: begin
          dec_offset[15:8] = b;
          if (dec_offset == END_OFFSET) begin
            emit = 1'b1;
            op.done = 1'b1;
            advance = 1'b0;
            dec_hdr_idx = '0;
          end
        end
        SPR_SIZE_LO: dec_size = {8'h00, b};
        SPR_SIZE_HI: dec_size[15:8] = b;
        SPR_LAST: start_run = 1'b1;
        default: ;
      endcase
    end
    // An empty run returns straight to the header.
    if (start_run) begin
      advance = 1'b0;
      dec_hdr_idx = '0;
      dec_pos = '0;
      dec_in_run = (dec_size != '0);
    end
    if (advance) dec_hdr_idx = dec_hdr_idx + 1'b1;
    if (emit) pending_ops.push_back(op);
  endtask

  // Presents one stream byte, with random gaps, and waits for its request
  // to be taken.
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    decode_stream_byte(b);
    n_bytes++;
  endtask

  // Random byte that never sets a large run size, so runs stay short.
  task automatic send_noise_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (!dec_in_run && ((rec_mode == MODE_ANIM && dec_hdr_idx == ANM_LEN_HI) ||
                        (rec_mode != MODE_ANIM && dec_hdr_idx == SPR_SIZE_HI))) begin
      b = 8'h00;
    end
    send_byte(b);
  endtask

  // Holds the stream until every queued result is out and the pipe is empty.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_ops.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes one register once the decoder has gone quiet.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [BASE_W-1:0] data);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_RECORD_MODE) rec_mode = data[MODE_W-1:0];
    else base_addr = data;
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Sends the first cut bytes of a record header in the current format.
  task automatic send_record(input logic [WORD_W-1:0] run_start,
                             input logic [WORD_W-1:0] len, input int cut);
    logic [7:0] hdr[SPR_HDR_BYTES];
    int         hdr_len;
    foreach (hdr[i]) hdr[i] = 8'($urandom_range(255));
    if (rec_mode == MODE_ANIM) begin
      hdr_len = ANM_HDR_BYTES;
      hdr[ANM_POS_LO] = run_start[7:0];
      hdr[ANM_POS_HI] = run_start[15:8];
      hdr[ANM_LEN_LO] = len[7:0];
      hdr[ANM_LEN_HI] = len[15:8];
      // The leading word must not read as a terminator.
      if (hdr[ANM_TERM_LO] == 8'h00 && hdr[ANM_TERM_HI] == 8'h00) hdr[ANM_TERM_HI] = 8'h01;
    end else begin
      hdr_len = SPR_HDR_BYTES;
      hdr[SPR_OFF_LO] = run_start[7:0];
      hdr[SPR_OFF_HI] = run_start[15:8];
      hdr[SPR_SIZE_LO] = len[7:0];
      hdr[SPR_SIZE_HI] = len[15:8];
    end
    for (int i = 0; i < hdr_len && i < cut; i++) send_byte(hdr[i]);
  endtask

  task automatic send_payload(input int len);
    for (int i = 0; i < len; i++) send_byte(8'($urandom_range(255)));
  endtask

  // Terminator record of the current format.
  task automatic send_list_end();
    if (rec_mode == MODE_ANIM) begin
      send_byte(8'h00);
      send_byte(8'h00);
    end else begin
      for (int i = 0; i < SPR_OFF_LO; i++) send_byte(8'($urandom_range(255)));
      send_byte(END_OFFSET[7:0]);
      send_byte(END_OFFSET[15:8]);
    end
  endtask

  function automatic logic [WORD_W-1:0] pick_offset();
    logic [WORD_W-1:0] v;
    case ($urandom_range(9))
      0: v = '0;
      1: v = 16'hFFFE;
      default: v = WORD_W'($urandom_range(16'hFFFF));
    endcase
    if (v == END_OFFSET) v = 16'hFFFE;
    return v;
  endfunction

  function automatic logic [WORD_W-1:0] pick_size();
    case ($urandom_range(19))
      0: return '0;
      1: return WORD_W'($urandom_range(300, 9));
      default: return WORD_W'($urandom_range(8, 1));
    endcase
  endfunction

  function automatic logic [BASE_W-1:0] pick_base();
    case ($urandom_range(3))
      0: return '0;
      1: return {BASE_W{1'b1}};
      default: return BASE_W'($urandom());
    endcase
  endfunction

  // Draw with the largest base, then shade with a zero base, then the
  // sprite terminator.
  task automatic test_sprite_formats();
    cfg_write(REG_RECORD_MODE, BASE_W'(MODE_DRAW));
    cfg_write(REG_BASE_ADDRESS, {BASE_W{1'b1}});
    send_record(16'hFFFE, 16'd2, SPR_HDR_BYTES);
    send_byte(8'h00);
    send_byte(8'hFF);
    cfg_write(REG_RECORD_MODE, BASE_W'(MODE_SHADE));
    cfg_write(REG_BASE_ADDRESS, '0);
    send_record(16'h0000, 16'd1, SPR_HDR_BYTES);
    send_payload(1);
    send_list_end();
  endtask

  // Animation records: an empty run, then a run whose payload arrives after
  // a switch to the unused mode code, which must still write pixels.
  task automatic test_anim_format();
    cfg_write(REG_RECORD_MODE, BASE_W'(MODE_ANIM));
    cfg_write(REG_BASE_ADDRESS, 24'h800000);
    send_record(16'h1234, 16'd0, ANM_HDR_BYTES);
    send_record(16'hFFFF, 16'd2, ANM_HDR_BYTES);
    cfg_write(REG_RECORD_MODE, BASE_W'(MODE_UNUSED));
    send_byte(8'hFF);
    send_byte(8'h00);
  endtask

  // A sprite header left at byte 10, then animation mode: the remaining
  // positions are skipped, the index wraps, and a zero word ends the list.
  task automatic test_header_wrap();
    cfg_write(REG_RECORD_MODE, BASE_W'(MODE_DRAW));
    send_record(16'h0100, 16'd1, SPR_OFF_HI + 1);
    cfg_write(REG_RECORD_MODE, BASE_W'(MODE_ANIM));
    repeat (SPR_HDR_BYTES - SPR_OFF_HI - 1) send_byte(8'($urandom_range(255)));
    send_list_end();
  endtask

  // Mostly well-formed lists with random content, plus noise, cut-off
  // headers and register changes between and inside records.
  task automatic test_random_lists(input int gap_pct, input int stall_pct, input int count);
    int            first;
    int            hdr_len;
    logic [WORD_W-1:0] len;
    in_gap_pct = gap_pct;
    out_stall_pct = stall_pct;
    cfg_write(REG_RECORD_MODE, BASE_W'($urandom_range(3)));
    cfg_write(REG_BASE_ADDRESS, pick_base());
    first = n_bytes;
    while (n_bytes - first < count) begin
      hdr_len = (rec_mode == MODE_ANIM) ? ANM_HDR_BYTES : SPR_HDR_BYTES;
      case ($urandom_range(9)) inside
        [0:6]: begin
          // Bring the parser back to a record boundary first.
          while (dec_in_run || dec_hdr_idx != '0) send_noise_byte();
          repeat ($urandom_range(4, 1)) begin
            len = pick_size();
            send_record(pick_offset(), len, hdr_len);
            send_payload(len);
          end
          send_list_end();
        end
        7: repeat ($urandom_range(16, 1)) send_noise_byte();
        8: begin
          send_record(pick_offset(), pick_size(), $urandom_range(hdr_len - 1, 1));
          if ($urandom_range(1)) cfg_write(REG_RECORD_MODE, BASE_W'($urandom_range(3)));
        end
        default: begin
          if ($urandom_range(1)) cfg_write(REG_RECORD_MODE, BASE_W'($urandom_range(3)));
          else cfg_write(REG_BASE_ADDRESS, pick_base());
        end
      endcase
    end
  endtask

  // Result side back-pressure.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Result checker
  always @(posedge clk) begin : check_results
    pixel_op_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_ops.size() == 0) begin
        report_mismatch("result with nothing expected", 32'(out_tdata[ADDR_W-1:0]), '0);
      end else begin
        want = pending_ops.pop_front();
        case (want.kind)
          OP_WRITE: n_writes++;
          OP_SHADE: n_shades++;
          default:  n_ends++;
        endcase
        if (out_tdata[ADDR_W-1:0] !== want.addr)
          report_mismatch("pixel_address", 32'(out_tdata[ADDR_W-1:0]), 32'(want.addr));
        if (out_tdata[ADDR_W +: BYTE_W] !== want.value)
          report_mismatch("pixel_value", 32'(out_tdata[ADDR_W +: BYTE_W]), 32'(want.value));
        if (out_tuser !== want.kind)
          report_mismatch("op_kind", 32'(out_tuser), 32'(want.kind));
        if (out_tlast !== want.done)
          report_mismatch("list_done", 32'(out_tlast), 32'(want.done));
      end
    end
  end

  // Watchdog on cycles with no request taken on any channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[%0t] Timeout: no request taken for %0d cycles", $realtime, QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // Test sequence
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    in_gap_pct = 28;
    out_stall_pct = 88;
    test_sprite_formats();
    test_anim_format();
    test_header_wrap();
    test_random_lists(28, 88, 200);
    test_random_lists(88, 28, 200);
    test_random_lists(0, 0, 200);
    wait_idle();
    if (pending_ops.size() != 0)
      report_mismatch("results never seen", 32'(pending_ops.size()), '0);
    $display("Run covered %0d stream bytes and %0d register writes in all record modes,",
             n_bytes, n_cfg);
    $display("checking %0d pixel writes, %0d shade operations and %0d list ends.",
             n_writes, n_shades, n_ends);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
